FILE: hdl/cube_map_face_select_unit_defines.svh
// Assertion helpers for the cube map face select block.
`ifndef CUBE_MAP_FACE_SELECT_UNIT_DEFINES_SVH
`define CUBE_MAP_FACE_SELECT_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CMFS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Delayed check: cons must hold the stated number of cycles after ante.
`define CMFS_ASSERT_DELAY(label, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error(msg);

`endif

FILE: hdl/cmfs_pkg.sv
`timescale 1ns / 1ps
package cmfs_pkg;

    // Field widths
    localparam int COMPONENT_BITS = 16;
    localparam int UV_BITS        = 16;

    // Cycles from accepted start to done
    localparam int PIPE_LAT = UV_BITS + 3;

    typedef logic signed [COMPONENT_BITS-1:0] comp_t;
    typedef logic [COMPONENT_BITS-1:0]        mag_t;
    typedef logic signed [COMPONENT_BITS:0]   minor_t;
    typedef logic [COMPONENT_BITS:0]          num_t;
    typedef logic [UV_BITS-1:0]               uv_t;
    typedef logic [2:0]                       face_t;

    // Per-beat flags carried along the divider
    typedef struct packed {
        logic sat;
        logic zero;
    } div_ctrl_t;

    // Face codes
    localparam face_t FACE_PX = 3'd0;
    localparam face_t FACE_NX = 3'd1;
    localparam face_t FACE_PY = 3'd2;
    localparam face_t FACE_NY = 3'd3;
    localparam face_t FACE_PZ = 3'd4;
    localparam face_t FACE_NZ = 3'd5;

    // Coordinate for a zero vector and the saturated coordinate
    localparam uv_t UV_HALF = uv_t'(1) << (UV_BITS - 1);
    localparam uv_t UV_MAX  = '1;

endpackage

FILE: hdl/cmfs_div_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring fraction divider, one quotient bit per stage: quo = num * 2^UV / den.
module cmfs_div_pipe (
    input  wire logic              clk,
    input  wire cmfs_pkg::num_t    num,
    input  wire cmfs_pkg::num_t    den,
    input  wire cmfs_pkg::div_ctrl_t ctrl,
    output cmfs_pkg::uv_t          quo
);
    import cmfs_pkg::*;

    num_t      r_reg    [0:UV_BITS-1];
    num_t      d_reg    [0:UV_BITS-1];
    uv_t       q_reg    [0:UV_BITS-1];
    div_ctrl_t ctrl_reg [0:UV_BITS-1];
    uv_t       quo_reg;

    // Stage 0 loads the operands
    always_ff @(posedge clk)
    begin
        r_reg[0]    <= num;
        d_reg[0]    <= den;
        q_reg[0]    <= '0;
        ctrl_reg[0] <= ctrl;
    end

    for (genvar i = 0; i < UV_BITS; i++)
    begin : g_step
        logic [COMPONENT_BITS+1:0] r2;
        logic [COMPONENT_BITS+1:0] diff;
        logic                      ge;
        uv_t                       q_next;

        // Shift remainder, trial subtract, one quotient bit
        always_comb
        begin
            r2     = {r_reg[i], 1'b0};
            diff   = r2 - {1'b0, d_reg[i]};
            ge     = (r2 >= {1'b0, d_reg[i]});
            q_next = {q_reg[i][UV_BITS-2:0], ge};
        end

        if (i < UV_BITS - 1)
        begin : g_mid
            // Remainder only travels on to a following stage
            always_ff @(posedge clk)
            begin
                r_reg[i+1]    <= ge ? diff[COMPONENT_BITS:0] : r2[COMPONENT_BITS:0];
                d_reg[i+1]    <= d_reg[i];
                q_reg[i+1]    <= q_next;
                ctrl_reg[i+1] <= ctrl_reg[i];
            end
        end
        else
        begin : g_last
            // Zero vector and minor == major override the quotient
            always_ff @(posedge clk)
            begin
                priority if (ctrl_reg[i].zero)
                    quo_reg <= UV_HALF;
                else if (ctrl_reg[i].sat)
                    quo_reg <= UV_MAX;
                else
                    quo_reg <= q_next;
            end
        end
    end

    assign quo = quo_reg;

endmodule
`default_nettype wire

FILE: hdl/cube_map_face_select_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// done rises once the start beat has passed stage 1, stage 2 and the divider stages to the output register.
// Throughput: one beat per cycle, busy is never raised; each beat gives one result.
// The divider resolves one quotient bit per stage, which sets the latency.
// Reset (rst_n low, async) clears all valid bits and done; no beat is in flight after it.
module cube_map_face_select_unit (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire cmfs_pkg::comp_t dir_x,
    input  wire cmfs_pkg::comp_t dir_y,
    input  wire cmfs_pkg::comp_t dir_z,
    output logic                 done,
    output cmfs_pkg::face_t      face,
    output cmfs_pkg::uv_t        tex_u,
    output cmfs_pkg::uv_t        tex_v,
    output logic                 zero_dir
);
    import cmfs_pkg::*;

    `include "cube_map_face_select_unit_defines.svh"

    // Stage 1: components and magnitudes
    logic  s1_vld_reg;
    comp_t x_reg, y_reg, z_reg;
    mag_t  ax_reg, ay_reg, az_reg;
    mag_t  ax_next, ay_next, az_next;

    assign ax_next = dir_x[COMPONENT_BITS-1] ? mag_t'(-dir_x) : mag_t'(dir_x);
    assign ay_next = dir_y[COMPONENT_BITS-1] ? mag_t'(-dir_y) : mag_t'(dir_y);
    assign az_next = dir_z[COMPONENT_BITS-1] ? mag_t'(-dir_z) : mag_t'(dir_z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else
            s1_vld_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        x_reg  <= dir_x;
        y_reg  <= dir_y;
        z_reg  <= dir_z;
        ax_reg <= ax_next;
        ay_reg <= ay_next;
        az_reg <= az_next;
    end

    // Stage 2: major axis, face, mirrored minors
    logic   s2_vld_reg;
    face_t  face2_reg, face2_next;
    mag_t   k_reg, k_next;
    minor_t a_reg, a_next, b_reg, b_next;
    logic   zero2_reg, zero2_next;
    minor_t xw, yw, zw;

    always_comb
    begin
        xw = {x_reg[COMPONENT_BITS-1], x_reg};
        yw = {y_reg[COMPONENT_BITS-1], y_reg};
        zw = {z_reg[COMPONENT_BITS-1], z_reg};
        zero2_next = (ax_reg == '0) && (ay_reg == '0) && (az_reg == '0);
        // Strict compares: ties go to y, then z
        priority if ((ax_reg > ay_reg) && (ax_reg > az_reg))
        begin
            k_next = ax_reg;
            b_next = yw;
            if (!x_reg[COMPONENT_BITS-1] && (x_reg != '0))
            begin
                face2_next = FACE_PX;
                a_next     = -zw;
            end
            else
            begin
                face2_next = FACE_NX;
                a_next     = zw;
            end
        end
        else if (ay_reg > az_reg)
        begin
            k_next = ay_reg;
            a_next = xw;
            if (!y_reg[COMPONENT_BITS-1] && (y_reg != '0))
            begin
                face2_next = FACE_PY;
                b_next     = -zw;
            end
            else
            begin
                face2_next = FACE_NY;
                b_next     = zw;
            end
        end
        else
        begin
            k_next = az_reg;
            b_next = yw;
            if (!z_reg[COMPONENT_BITS-1] && (z_reg != '0))
            begin
                face2_next = FACE_PZ;
                a_next     = xw;
            end
            else
            begin
                face2_next = FACE_NZ;
                a_next     = -xw;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        face2_reg <= face2_next;
        k_reg     <= k_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        zero2_reg <= zero2_next;
    end

    // Divider operands: num = minor + k in [0, 2k], den = 2k
    logic signed [COMPONENT_BITS+1:0] nu_w, nv_w;
    num_t      nu, nv, den;
    div_ctrl_t ctrl_u, ctrl_v;

    always_comb
    begin
        nu_w        = {a_reg[COMPONENT_BITS], a_reg} + {2'b00, k_reg};
        nv_w        = {b_reg[COMPONENT_BITS], b_reg} + {2'b00, k_reg};
        nu          = nu_w[COMPONENT_BITS:0];
        nv          = nv_w[COMPONENT_BITS:0];
        den         = {k_reg, 1'b0};
        ctrl_u.sat  = (nu == den);
        ctrl_u.zero = zero2_reg;
        ctrl_v.sat  = (nv == den);
        ctrl_v.zero = zero2_reg;
    end

    cmfs_div_pipe u_div_u (
        .clk  (clk),
        .num  (nu),
        .den  (den),
        .ctrl (ctrl_u),
        .quo  (tex_u)
    );

    cmfs_div_pipe u_div_v (
        .clk  (clk),
        .num  (nv),
        .den  (den),
        .ctrl (ctrl_v),
        .quo  (tex_v)
    );

    // Sideband line alongside the divider stages
    logic  vld_pipe_reg  [0:UV_BITS-1];
    face_t face_pipe_reg [0:UV_BITS-1];
    logic  zero_pipe_reg [0:UV_BITS-1];
    logic  done_reg;
    face_t face_reg;
    logic  zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < UV_BITS; i++)
                vld_pipe_reg[i] <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_pipe_reg[0] <= s2_vld_reg;
            for (int i = 1; i < UV_BITS; i++)
                vld_pipe_reg[i] <= vld_pipe_reg[i-1];
            done_reg <= vld_pipe_reg[UV_BITS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        face_pipe_reg[0] <= face2_reg;
        zero_pipe_reg[0] <= zero2_reg;
        for (int i = 1; i < UV_BITS; i++)
        begin
            face_pipe_reg[i] <= face_pipe_reg[i-1];
            zero_pipe_reg[i] <= zero_pipe_reg[i-1];
        end
        face_reg <= face_pipe_reg[UV_BITS-1];
        zero_reg <= zero_pipe_reg[UV_BITS-1];
    end

    assign busy     = 1'b0;
    assign done     = done_reg;
    assign face     = face_reg;
    assign zero_dir = zero_reg;

    // Checks
    `CMFS_ASSERT_DELAY(a_latency, start, PIPE_LAT, done, "result missing after start")
    `CMFS_ASSERT_IMPL(a_face_range, done, face <= FACE_NZ, "face code out of range")
    `CMFS_ASSERT_IMPL(a_zero_result, done && zero_dir,
        (face == FACE_NZ) && (tex_u == UV_HALF) && (tex_v == UV_HALF),
        "zero vector result wrong")

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import cmfs_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RESET_CYCLES = 4;
    localparam int RANDOM_BEATS = 1700;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_LIMIT  = 4 * PIPE_LAT + 100;

    // One expected lookup result
    typedef struct {
        face_t face;
        uv_t   u;
        uv_t   v;
        logic  zero;
    } texel_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  start = 1'b0;
    comp_t dir_x = '0;
    comp_t dir_y = '0;
    comp_t dir_z = '0;
    logic  busy;
    logic  done;
    face_t face;
    uv_t   tex_u;
    uv_t   tex_v;
    logic  zero_dir;

    texel_t pending_texels[$];
    int     error_count = 0;
    int     beats_sent = 0;
    int     texels_checked = 0;
    int     face_hits[6];
    int     cycle_count = 0;

    cube_map_face_select_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .dir_x    (dir_x),
        .dir_y    (dir_y),
        .dir_z    (dir_z),
        .done     (done),
        .face     (face),
        .tex_u    (tex_u),
        .tex_v    (tex_v),
        .zero_dir (zero_dir)
    );

    always #CLK_HALF clk = ~clk;

    // Minor component over major magnitude, mapped to 0.UV_BITS, saturated
    function automatic uv_t map_to_uv(longint a, longint k);
        longint q;
        q = ((a + k) <<< UV_BITS) / (2 * k);
        if (q > longint'(UV_MAX))
            return UV_MAX;
        return uv_t'(q);
    endfunction

    // Face pick and face coordinates for one direction
    function automatic texel_t predict_face_lookup(comp_t x, comp_t y, comp_t z);
        texel_t r;
        longint sx, sy, sz, ax, ay, az, k, a, b;
        sx = x;
        sy = y;
        sz = z;
        ax = (sx < 0) ? -sx : sx;
        ay = (sy < 0) ? -sy : sy;
        az = (sz < 0) ? -sz : sz;
        r.zero = 1'b0;
        // zero vector: -Z face, centered coordinates, flag set
        if (ax == 0 && ay == 0 && az == 0) begin
            r.face = FACE_NZ;
            r.u    = UV_HALF;
            r.v    = UV_HALF;
            r.zero = 1'b1;
            return r;
        end
        // strict compares: ties fall to y, then z
        if (ax > ay && ax > az) begin
            k = ax;
            if (sx > 0) begin r.face = FACE_PX; a = -sz; b = sy; end
            else        begin r.face = FACE_NX; a = sz;  b = sy; end
        end else if (ay > az) begin
            k = ay;
            if (sy > 0) begin r.face = FACE_PY; a = sx; b = -sz; end
            else        begin r.face = FACE_NY; a = sx; b = sz;  end
        end else begin
            k = az;
            if (sz > 0) begin r.face = FACE_PZ; a = sx;  b = sy; end
            else        begin r.face = FACE_NZ; a = -sx; b = sy; end
        end
        r.u = map_to_uv(a, k);
        r.v = map_to_uv(b, k);
        return r;
    endfunction

    // Present one beat and hold it until taken; start stays high afterward
    task automatic issue_dir(comp_t x, comp_t y, comp_t z);
        start <= 1'b1;
        dir_x <= x;
        dir_y <= y;
        dir_z <= z;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_texels.push_back(predict_face_lookup(x, y, z));
        beats_sent++;
    endtask

    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Random component in [lo, hi]
    function automatic comp_t rand_comp(int lo, int hi);
        return comp_t'(lo + int'($urandom_range(0, hi - lo)));
    endfunction

    function automatic comp_t rand_sign(int m);
        return comp_t'($urandom_range(0, 1) ? m : -m);
    endfunction

    // Result checker: every done cycle pops the oldest expectation
    always @(posedge clk) begin : texel_check
        texel_t want;
        if (rst_n && done) begin
            if (pending_texels.size() == 0) begin
                $error("result with nothing pending: face=%0d u=%0d v=%0d",
                       face, tex_u, tex_v);
                error_count++;
            end else begin
                want = pending_texels.pop_front();
                texels_checked++;
                if (face < 6)
                    face_hits[face]++;
                if (face !== want.face) begin
                    $error("face: expected %0d, got %0d", want.face, face);
                    error_count++;
                end
                if (tex_u !== want.u) begin
                    $error("tex_u: expected %0d, got %0d", want.u, tex_u);
                    error_count++;
                end
                if (tex_v !== want.v) begin
                    $error("tex_v: expected %0d, got %0d", want.v, tex_v);
                    error_count++;
                end
                if (zero_dir !== want.zero) begin
                    $error("zero_dir: expected %0b, got %0b", want.zero, zero_dir);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Zero vector gives the flagged -Z result
    task automatic test_zero_vector();
        issue_dir(16'sd0, 16'sd0, 16'sd0);
    endtask

    // One beat per face, clear major axis
    task automatic test_face_axes();
        issue_dir( 16'sd1000,   16'sd200,  -16'sd300);
        issue_dir(-16'sd1000,   16'sd200,  -16'sd300);
        issue_dir(  16'sd200,  16'sd1000,  -16'sd300);
        issue_dir(  16'sd200, -16'sd1000,  -16'sd300);
        issue_dir(  16'sd200,  -16'sd300,  16'sd1000);
        issue_dir(  16'sd200,  -16'sd300, -16'sd1000);
    endtask

    // Full-scale and most negative components
    task automatic test_extremes();
        issue_dir(-16'sd32768,  16'sd32767, -16'sd32767);
        issue_dir( 16'sd32767, -16'sd32768,  16'sd32767);
        issue_dir( 16'sd32767,  16'sd32767, -16'sd32768);
        issue_dir(-16'sd32768, -16'sd32768, -16'sd32768);
        issue_dir( 16'sd32767,  16'sd0,      16'sd0);
        issue_dir( 16'sd0,      16'sd0,      16'sd1);
        issue_dir(-16'sd1,      16'sd0,      16'sd0);
    endtask

    // Equal magnitudes: y beats x, z beats both
    task automatic test_ties();
        issue_dir( 16'sd500,  -16'sd500,  16'sd10);
        issue_dir(-16'sd500,   16'sd10,   16'sd500);
        issue_dir( 16'sd10,   -16'sd500, -16'sd500);
        issue_dir( 16'sd777,   16'sd777,  16'sd777);
        issue_dir(-16'sd777,  -16'sd777, -16'sd777);
    endtask

    // Minor equal to +major saturates; the other beats put minors just below the major
    task automatic test_saturation();
        issue_dir( 16'sd4000,  16'sd4000, -16'sd3999);
        issue_dir(-16'sd3999, -16'sd4000,  16'sd3999);
        issue_dir( 16'sd100,   16'sd100,   16'sd101);
        issue_dir(-16'sd101,  -16'sd100,  -16'sd100);
        issue_dir(-16'sd32768, 16'sd32767,-16'sd32767);
    endtask

    // Random directions in bursts, most bursts followed by a random gap
    task automatic test_random_mix();
        int burst_len;
        int sent;
        int mode;
        int m;
        comp_t cx, cy, cz;
        sent = 0;
        while (sent < RANDOM_BEATS) begin
            burst_len = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 16);
            repeat (burst_len) begin
                mode = $urandom_range(0, 5);
                cx = comp_t'($urandom());
                cy = comp_t'($urandom());
                cz = comp_t'($urandom());
                case (mode)
                    1: begin
                        // small values: many ties and zeros
                        cx = rand_comp(-3, 3);
                        cy = rand_comp(-3, 3);
                        cz = rand_comp(-3, 3);
                    end
                    2: begin
                        // one axis at full scale
                        m = $urandom_range(0, 1) ? -32768 : 32767;
                        case ($urandom_range(0, 2))
                            0: cx = comp_t'(m);
                            1: cy = comp_t'(m);
                            default: cz = comp_t'(m);
                        endcase
                    end
                    3: begin
                        // two or three axes share one magnitude
                        m = $urandom_range(1, 32768);
                        cx = rand_sign(m);
                        cy = rand_sign(m);
                        if ($urandom_range(0, 1))
                            cz = rand_sign(m);
                        else
                            cz = rand_comp(-m + 1, m - 1);
                    end
                    4: begin
                        // x one below the major z, y within that, on the +Z or -Z face
                        m = $urandom_range(1, 32767);
                        cx = rand_sign(m);
                        cy = rand_comp(-m, m);
                        cz = rand_sign(m + 1);
                    end
                    default: ;
                endcase
                issue_dir(cx, cy, cz);
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 6));
        end
    endtask

    // Sequencer
    initial begin
        int drain;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_vector();
        test_face_axes();
        idle_cycles(3);
        test_extremes();
        test_ties();
        idle_cycles(1);
        test_saturation();
        test_random_mix();
        start <= 1'b0;

        // drain the pipe, then let it settle
        drain = 0;
        while (pending_texels.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge clk);
            drain++;
        end
        if (pending_texels.size() != 0) begin
            $error("%0d results never arrived", pending_texels.size());
            error_count += pending_texels.size();
        end
        repeat (PIPE_LAT + 4) @(posedge clk);

        $display("sent %0d direction beats, checked %0d results, %0d errors",
                 beats_sent, texels_checked, error_count);
        $display("face hits +X %0d -X %0d +Y %0d -Y %0d +Z %0d -Z %0d",
                 face_hits[0], face_hits[1], face_hits[2],
                 face_hits[3], face_hits[4], face_hits[5]);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
